// ===== design/lfec_pkg.sv =====
// ----------------------------------------------------------------------------
// lfec_pkg
// Types and codes shared by the factoring evidence cache modules.
// ----------------------------------------------------------------------------
package lfec_pkg;

    // operation codes
    localparam logic [1:0] OP_TRIAL  = 2'd0;
    localparam logic [1:0] OP_FERMAT = 2'd1;
    localparam logic [1:0] OP_AUTO   = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    // last method codes
    localparam logic [4:0] METH_NONE   = 5'd0;
    localparam logic [4:0] METH_TRIAL  = 5'd1;
    localparam logic [4:0] METH_FERMAT = 5'd2;
    localparam logic [4:0] METH_AUTO   = 5'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key;
        logic [63:0] bound;
        logic        complete;
        logic [63:0] cofactor;
        logic [6:0]  n_factors;
        logic [63:0] first_factor;
        logic [3:0]  router_method;
        logic        router_wheel;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic        wheel_checked;
        logic        wheel_factor;
        logic        trial_seen;
        logic [63:0] trial_max;
        logic        fermat_seen;
        logic [63:0] fermat_max;
        logic        fermat_ok;
        logic        factor_hit;
        logic [63:0] factor_value;
        logic [4:0]  method_code;
    } rsp_t;

    typedef struct packed {
        logic factor_hit;
        logic fermat_ok;
        logic fermat_seen;
        logic trial_seen;
        logic wheel_factor;
        logic wheel_checked;
    } flags_t;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] age;
        flags_t      flags;
        logic [63:0] trial_limit;
        logic [63:0] step_count;
        logic [63:0] factor;
        logic [4:0]  method;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_MERGE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic fetch;
        logic merge;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } status_t;

endpackage

// ===== design/lfec_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfec_ctrl
// Sequencer for one cache operation: tag scan, entry fetch, merge and write.
// ----------------------------------------------------------------------------
module lfec_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  lfec_pkg::status_t status,
    output lfec_pkg::cmd_t    cmd
);

    lfec_pkg::state_t state_reg;
    lfec_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfec_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfec_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lfec_pkg::ST_SCAN;
                end
            end
            lfec_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = lfec_pkg::ST_FETCH;
                end
            end
            lfec_pkg::ST_FETCH:
            begin
                state_next = lfec_pkg::ST_MERGE;
            end
            lfec_pkg::ST_MERGE:
            begin
                if (!status.out_busy)
                begin
                    state_next = lfec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfec_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        case (state_reg)
            lfec_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            lfec_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            lfec_pkg::ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            lfec_pkg::ST_MERGE:
            begin
                cmd.merge = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/lfec_dpath.sv =====
// ----------------------------------------------------------------------------
// lfec_dpath
// Entry memory, tag and age scan, evidence merge and result register.
// ----------------------------------------------------------------------------
module lfec_dpath #(
    parameter int CACHE_ENTRIES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lfec_pkg::req_t    req,
    output lfec_pkg::rsp_t    rsp,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  lfec_pkg::cmd_t    cmd,
    output lfec_pkg::status_t status
);

    localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(CACHE_ENTRIES);

    // valid entries always form a prefix, so a fill count replaces valid bits
    lfec_pkg::entry_t mem [CACHE_ENTRIES];
    lfec_pkg::entry_t rdata_reg;

    lfec_pkg::req_t   req_reg;
    logic [CW-1:0]    fill_reg;
    logic [63:0]      clock_reg;
    logic [CW-1:0]    scan_idx_reg;
    logic             cmp_vld_reg;
    logic [AW-1:0]    cmp_idx_reg;
    logic             hit_reg;
    logic [AW-1:0]    hit_idx_reg;
    logic [63:0]      min_age_reg;
    logic [AW-1:0]    min_idx_reg;
    lfec_pkg::rsp_t   rsp_reg;
    logic             rsp_valid_reg;

    logic             issue;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    tgt_idx;
    logic             is_record;
    logic             alloc;
    logic [63:0]      clock_inc;
    logic             done_ok;
    logic             has_cnt;
    lfec_pkg::entry_t base;
    lfec_pkg::entry_t upd;
    lfec_pkg::rsp_t   rsp_next;

    assign issue     = cmd.scan && (scan_idx_reg < fill_reg);
    assign rd_addr   = cmd.fetch ? hit_idx_reg : scan_idx_reg[AW-1:0];
    assign is_record = (req_reg.opcode != lfec_pkg::OP_LOOKUP);
    assign alloc     = is_record && !hit_reg;
    assign tgt_idx   = hit_reg ? hit_idx_reg :
                       (fill_reg < FULL) ? fill_reg[AW-1:0] : min_idx_reg;
    assign clock_inc = clock_reg + 64'd1;
    assign done_ok   = !req_reg.complete || (req_reg.cofactor > 64'd1);
    assign has_cnt   = (req_reg.n_factors != 7'd0);

    assign status.scan_done = !cmp_vld_reg && (scan_idx_reg == fill_reg);
    assign status.out_busy  = rsp_valid_reg && !rsp_ready;

    // entry memory with registered read, read data held through the merge
    always_ff @(posedge clk)
    begin
        if (cmd.scan || cmd.fetch)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.merge && is_record)
        begin
            mem[tgt_idx] <= upd;
        end
    end

    // captured request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    // scan control and search results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= issue;
            if (issue)
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
            if (cmp_vld_reg && !hit_reg && rdata_reg.key == req_reg.key)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // hit index and oldest entry, lowest index wins ties
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            min_age_reg <= '1;
            min_idx_reg <= '0;
        end
        else if (cmp_vld_reg)
        begin
            if (!hit_reg && rdata_reg.key == req_reg.key)
            begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (rdata_reg.age < min_age_reg)
            begin
                min_age_reg <= rdata_reg.age;
                min_idx_reg <= cmp_idx_reg;
            end
        end
        if (issue)
        begin
            cmp_idx_reg <= scan_idx_reg[AW-1:0];
        end
    end

    // merge of the outcome into the entry
    always_comb
    begin
        if (hit_reg)
        begin
            base = rdata_reg;
        end
        else
        begin
            base     = '0;
            base.key = req_reg.key;
        end
        upd     = base;
        upd.age = clock_inc;
        upd.flags.wheel_checked = 1'b1;
        case (req_reg.opcode)
            lfec_pkg::OP_TRIAL:
            begin
                if (done_ok)
                begin
                    if (!base.flags.trial_seen || req_reg.bound > base.trial_limit)
                    begin
                        upd.flags.trial_seen = 1'b1;
                        upd.trial_limit      = req_reg.bound;
                    end
                end
                else if (has_cnt)
                begin
                    upd.flags.factor_hit = 1'b1;
                    upd.factor           = req_reg.first_factor;
                end
                upd.method = lfec_pkg::METH_TRIAL;
            end
            lfec_pkg::OP_FERMAT:
            begin
                if (req_reg.complete)
                begin
                    upd.flags.fermat_ok  = 1'b1;
                    upd.flags.factor_hit = 1'b1;
                    if (has_cnt)
                    begin
                        upd.factor = req_reg.first_factor;
                    end
                end
                else
                begin
                    if (!base.flags.fermat_seen || req_reg.bound > base.step_count)
                    begin
                        upd.flags.fermat_seen = 1'b1;
                        upd.step_count        = req_reg.bound;
                    end
                    upd.flags.fermat_ok = 1'b0;
                end
                upd.method = lfec_pkg::METH_FERMAT;
            end
            default:
            begin
                if (req_reg.complete && has_cnt)
                begin
                    upd.flags.factor_hit = 1'b1;
                    upd.factor           = req_reg.first_factor;
                    if (req_reg.router_method != 4'd0 && req_reg.router_wheel)
                    begin
                        upd.flags.wheel_factor = 1'b1;
                    end
                end
                upd.method = (req_reg.router_method != 4'd0) ?
                             ({1'b0, req_reg.router_method} + lfec_pkg::METH_AUTO) :
                             lfec_pkg::METH_AUTO;
            end
        endcase
    end

    // result fields
    always_comb
    begin
        lfec_pkg::entry_t e;
        e = is_record ? upd : rdata_reg;
        rsp_next.hit           = 1'b1;
        rsp_next.wheel_checked = e.flags.wheel_checked;
        rsp_next.wheel_factor  = e.flags.wheel_factor;
        rsp_next.trial_seen    = e.flags.trial_seen;
        rsp_next.trial_max     = e.trial_limit;
        rsp_next.fermat_seen   = e.flags.fermat_seen;
        rsp_next.fermat_max    = e.step_count;
        rsp_next.fermat_ok     = e.flags.fermat_ok;
        rsp_next.factor_hit    = e.flags.factor_hit;
        rsp_next.factor_value  = e.factor;
        rsp_next.method_code   = e.method;
        if (!is_record && !hit_reg)
        begin
            rsp_next = '0;
        end
    end

    // fill count, access clock and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            clock_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.merge)
            begin
                rsp_valid_reg <= 1'b1;
                if (is_record)
                begin
                    clock_reg <= clock_inc;
                end
                if (alloc && fill_reg < FULL)
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.merge)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== design/lru_factoring_evidence_cache_unit.sv =====
// ----------------------------------------------------------------------------
// lru_factoring_evidence_cache_unit
// Fully associative LRU cache of factoring evidence keyed by a 64-bit number.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation: record
//   trial, record fermat, record auto, or lookup. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns one result per operation with the
//   entry contents after the operation.
//   The tag and age scan reads the entries in use from the entry memory
//   one entry per cycle through its single read port. One operation is in
//   work at a time, so a new request is taken only after the previous one
//   has finished its merge step.
//   Reset clears the fill count, the access clock and the result valid;
//   entries beyond the fill count are treated as empty, no clearing pass.
//   When the receiver stalls the result holds in its output register; the
//   next request is taken and scanned, and waits only at its merge step
//   until the held result transfers.
// ----------------------------------------------------------------------------
module lru_factoring_evidence_cache_unit #(
    parameter int CACHE_ENTRIES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lfec_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lfec_pkg::rsp_t rsp
);

    lfec_pkg::cmd_t    cmd;
    lfec_pkg::status_t status;

    // operation sequencer
    lfec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // storage and merge
    lfec_dpath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== design/lfec_checker.sv =====
// ----------------------------------------------------------------------------
// lfec_checker
// Port level checks for the factoring evidence cache, bound to the top level.
// ----------------------------------------------------------------------------
module lfec_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input lfec_pkg::rsp_t rsp
);

    // held result stays put until transfer
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // one operation in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // a miss returns all zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.hit |-> rsp == '0)
        else $error("miss result not zero");

    // every present entry has been recorded at least once
    a_hit_checked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.hit == rsp.wheel_checked)
        else $error("hit without wheel check mark");

endmodule

bind lru_factoring_evidence_cache_unit lfec_checker u_lfec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== tb/sv/tb_lru_factoring_evidence_cache_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_factoring_evidence_cache_unit
// Drives record and lookup operations into the evidence cache and checks each
// result against a behavioral copy of the cache, including LRU replacement.
// ----------------------------------------------------------------------------

class evidence_scoreboard;
    localparam int N = 64;
    bit               vld[N];
    logic [63:0]      ekey[N];
    logic [63:0]      eage[N];
    lfec_pkg::flags_t efl[N];
    logic [63:0]      etrial[N];
    logic [63:0]      esteps[N];
    logic [63:0]      efac[N];
    logic [4:0]       emeth[N];
    logic [63:0]      clk_count;
    lfec_pkg::rsp_t   pending[$];
    int               errors;
    int               checked;

    function void clear();
        foreach (vld[i]) vld[i] = 1'b0;
        clk_count = '0;
        pending.delete();
        errors = 0;
        checked = 0;
    endfunction

    function int find(logic [63:0] k);
        for (int i = 0; i < N; i++)
            if (vld[i] && ekey[i] == k) return i;
        return -1;
    endfunction

    // note one accepted request and queue its expected result
    function void note_request(lfec_pkg::req_t r);
        int s;
        logic [63:0] oldest;
        lfec_pkg::rsp_t e;
        lfec_pkg::flags_t f;
        oldest = '1;
        e = '0;
        if (r.opcode == lfec_pkg::OP_LOOKUP)
        begin
            s = find(r.key);
            if (s < 0)
            begin
                pending.push_back(e);
                return;
            end
        end
        else
        begin
            clk_count++;
            s = find(r.key);
            if (s < 0)
            begin
                s = 0;
                for (int i = 0; i < N; i++)
                begin
                    if (!vld[i])
                    begin
                        s = i;
                        break;
                    end
                    if (eage[i] < oldest)
                    begin
                        oldest = eage[i];
                        s = i;
                    end
                end
                vld[s] = 1'b1; ekey[s] = r.key; efl[s] = '0; etrial[s] = '0;
                esteps[s] = '0; efac[s] = '0; emeth[s] = lfec_pkg::METH_NONE;
            end
            eage[s] = clk_count;
            f = efl[s];
            f.wheel_checked = 1'b1;
            if (r.opcode == lfec_pkg::OP_TRIAL)
            begin
                if (!r.complete || r.cofactor > 64'd1)
                begin
                    if (!f.trial_seen || r.bound > etrial[s])
                    begin
                        f.trial_seen = 1'b1;
                        etrial[s] = r.bound;
                    end
                end
                else if (r.n_factors != 7'd0)
                begin
                    f.factor_hit = 1'b1;
                    efac[s] = r.first_factor;
                end
                emeth[s] = lfec_pkg::METH_TRIAL;
            end
            else if (r.opcode == lfec_pkg::OP_FERMAT)
            begin
                if (r.complete)
                begin
                    f.fermat_ok = 1'b1;
                    f.factor_hit = 1'b1;
                    if (r.n_factors != 7'd0) efac[s] = r.first_factor;
                end
                else
                begin
                    if (!f.fermat_seen || r.bound > esteps[s])
                    begin
                        f.fermat_seen = 1'b1;
                        esteps[s] = r.bound;
                    end
                    f.fermat_ok = 1'b0;
                end
                emeth[s] = lfec_pkg::METH_FERMAT;
            end
            else
            begin
                if (r.complete && r.n_factors != 7'd0)
                begin
                    f.factor_hit = 1'b1;
                    efac[s] = r.first_factor;
                    if (r.router_method != 4'd0 && r.router_wheel) f.wheel_factor = 1'b1;
                end
                emeth[s] = (r.router_method != 4'd0) ?
                           5'(r.router_method) + lfec_pkg::METH_AUTO : lfec_pkg::METH_AUTO;
            end
            efl[s] = f;
        end
        e.hit = 1'b1;
        e.wheel_checked = efl[s].wheel_checked;
        e.wheel_factor = efl[s].wheel_factor;
        e.trial_seen = efl[s].trial_seen;
        e.trial_max = etrial[s];
        e.fermat_seen = efl[s].fermat_seen;
        e.fermat_max = esteps[s];
        e.fermat_ok = efl[s].fermat_ok;
        e.factor_hit = efl[s].factor_hit;
        e.factor_value = efac[s];
        e.method_code = emeth[s];
        pending.push_back(e);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(lfec_pkg::rsp_t a);
        lfec_pkg::rsp_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result transfer");
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (a.hit !== e.hit)
        begin
            $error("hit exp %0h act %0h", e.hit, a.hit);
            errors++;
        end
        if (a.wheel_checked !== e.wheel_checked)
        begin
            $error("wheel_checked exp %0h act %0h", e.wheel_checked, a.wheel_checked);
            errors++;
        end
        if (a.wheel_factor !== e.wheel_factor)
        begin
            $error("wheel_factor exp %0h act %0h", e.wheel_factor, a.wheel_factor);
            errors++;
        end
        if (a.trial_seen !== e.trial_seen)
        begin
            $error("trial_seen exp %0h act %0h", e.trial_seen, a.trial_seen);
            errors++;
        end
        if (a.trial_max !== e.trial_max)
        begin
            $error("trial_max exp %0h act %0h", e.trial_max, a.trial_max);
            errors++;
        end
        if (a.fermat_seen !== e.fermat_seen)
        begin
            $error("fermat_seen exp %0h act %0h", e.fermat_seen, a.fermat_seen);
            errors++;
        end
        if (a.fermat_max !== e.fermat_max)
        begin
            $error("fermat_max exp %0h act %0h", e.fermat_max, a.fermat_max);
            errors++;
        end
        if (a.fermat_ok !== e.fermat_ok)
        begin
            $error("fermat_ok exp %0h act %0h", e.fermat_ok, a.fermat_ok);
            errors++;
        end
        if (a.factor_hit !== e.factor_hit)
        begin
            $error("factor_hit exp %0h act %0h", e.factor_hit, a.factor_hit);
            errors++;
        end
        if (a.factor_value !== e.factor_value)
        begin
            $error("factor_value exp %0h act %0h", e.factor_value, a.factor_value);
            errors++;
        end
        if (a.method_code !== e.method_code)
        begin
            $error("method_code exp %0h act %0h", e.method_code, a.method_code);
            errors++;
        end
    endfunction
endclass

module tb_lru_factoring_evidence_cache_unit;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    lfec_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    lfec_pkg::rsp_t rsp;

    evidence_scoreboard sb = new();
    bit   stim_done = 1'b0;
    bit   hold_rsp = 1'b0;
    logic [63:0] key_pool[16];

    lru_factoring_evidence_cache_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // one request transfer, then an optional gap
    task automatic send(lfec_pkg::req_t r, int gap);
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        sb.note_request(r);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic lfec_pkg::req_t make_req(logic [1:0] op, logic [63:0] k,
                                                logic [63:0] b, logic full,
                                                logic [63:0] cof, logic [6:0] cnt,
                                                logic [63:0] fac, logic [3:0] m,
                                                logic w);
        lfec_pkg::req_t r;
        r = '{op, k, b, full, cof, cnt, fac, m, w};
        return r;
    endfunction

    // random request; mostly within a small key pool to build hits and evictions
    function automatic lfec_pkg::req_t rand_req(int pool_size);
        lfec_pkg::req_t r;
        int c;
        r.opcode = 2'($urandom_range(0, 3));
        c = $urandom_range(0, 9);
        if (c < 8)
            r.key = key_pool[$urandom_range(0, pool_size - 1)] + 64'($urandom_range(0, 70));
        else
            r.key = rand64();
        r.bound = ($urandom_range(0, 1) != 0) ? 64'($urandom_range(0, 20)) : rand64();
        r.complete = 1'($urandom_range(0, 1));
        c = $urandom_range(0, 3);
        r.cofactor = (c == 0) ? rand64() : 64'($urandom_range(0, 2));
        c = $urandom_range(0, 3);
        r.n_factors = (c == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 2));
        r.first_factor = rand64();
        r.router_method = 4'($urandom_range(0, 15));
        r.router_wheel = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // receiver with random stalls and one long hold-off
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready) sb.check_result(rsp);
            if (hold_rsp) rsp_ready <= 1'b0;
            else
            begin
                g = gap_len();
                rsp_ready <= (g == 0) || ($urandom_range(0, 1) == 0);
            end
        end
    end

    // stimulus
    initial
    begin
        logic [63:0] ones;
        ones = '1;
        sb.clear();
        foreach (key_pool[i]) key_pool[i] = rand64();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lookup miss, each operation, extremes and special cases
        send(make_req(lfec_pkg::OP_LOOKUP, 64'd5, 64'd0, 1'b0, 64'd0, 7'd0, 64'd0,
                      4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_TRIAL, 64'd5, 64'd100, 1'b0, 64'd7, 7'd0, 64'd0,
                      4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_TRIAL, 64'd5, 64'd50, 1'b1, 64'd3, 7'd1, 64'd9,
                      4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_TRIAL, 64'd5, ones, 1'b1, 64'd1, 7'd2, 64'd3,
                      4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_TRIAL, 64'd5, 64'd0, 1'b1, 64'd0, 7'd0, 64'd3,
                      4'd0, 1'b0), 1);
        send(make_req(lfec_pkg::OP_FERMAT, 64'd5, 64'd10, 1'b0, 64'd0, 7'd0, 64'd0,
                      4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_FERMAT, 64'd5, 64'd4, 1'b0, 64'd0, 7'd0, 64'd0,
                      4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_FERMAT, 64'd5, 64'd0, 1'b1, 64'd0, 7'd0, ones,
                      4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_FERMAT, 64'd5, ones, 1'b1, ones, 7'd64, ones,
                      4'd0, 1'b0), 2);
        send(make_req(lfec_pkg::OP_AUTO, 64'd5, 64'd0, 1'b1, 64'd0, 7'd1, 64'd11,
                      4'd0, 1'b1), 0);
        send(make_req(lfec_pkg::OP_AUTO, 64'd5, 64'd0, 1'b1, 64'd0, 7'd127, 64'd13,
                      4'd15, 1'b1), 0);
        send(make_req(lfec_pkg::OP_AUTO, ones, ones, 1'b0, ones, 7'd127, ones,
                      4'd1, 1'b0), 0);
        send(make_req(lfec_pkg::OP_AUTO, 64'd0, 64'd0, 1'b1, 64'd0, 7'd3, 64'd2,
                      4'd7, 1'b0), 0);
        send(make_req(lfec_pkg::OP_LOOKUP, 64'd5, ones, 1'b1, ones, 7'd127, ones,
                      4'd15, 1'b1), 0);
        send(make_req(lfec_pkg::OP_LOOKUP, ones, 64'd0, 1'b0, 64'd0, 7'd0, 64'd0,
                      4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_LOOKUP, 64'd6, 64'd0, 1'b0, 64'd0, 7'd0, 64'd0,
                      4'd0, 1'b0), 0);
        // fill past capacity so LRU evicts the oldest entries
        for (int i = 0; i < 70; i++)
            send(make_req(lfec_pkg::OP_TRIAL, 64'h1000 + 64'(i), 64'(i), 1'b0, 64'd0,
                          7'd0, 64'd0, 4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_LOOKUP, 64'd5, 64'd0, 1'b0, 64'd0, 7'd0, 64'd0,
                      4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_LOOKUP, 64'h1000, 64'd0, 1'b0, 64'd0, 7'd0, 64'd0,
                      4'd0, 1'b0), 0);
        send(make_req(lfec_pkg::OP_LOOKUP, 64'h1045, 64'd0, 1'b0, 64'd0, 7'd0, 64'd0,
                      4'd0, 1'b0), 0);

        // long receiver hold-off while requests keep coming
        hold_rsp = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_rsp = 1'b0;
            end
            begin
                for (int i = 0; i < 20; i++) send(rand_req(4), 0);
                req_valid <= 1'b0;
            end
        join

        // random traffic, mostly well-formed over a small pool of keys
        for (int i = 0; i < 1800; i++)
            send(rand_req((i % 400 < 200) ? 2 : 16), gap_len());
        req_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d results over trial, fermat, auto and lookup operations,",
                 sb.checked);
        $display("with hits, misses, LRU evictions, stalls and a long receiver hold-off");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_lru_factoring_evidence_cache_unit: done, clean");
        else
            $display("tb_lru_factoring_evidence_cache_unit: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("tb_lru_factoring_evidence_cache_unit: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lfec_pkg.sv
design/lfec_ctrl.sv
design/lfec_dpath.sv
design/lru_factoring_evidence_cache_unit.sv
design/lfec_checker.sv
tb/sv/tb_lru_factoring_evidence_cache_unit.sv
